/* rtl/kwt_pkg.sv */
// Package for the Kaiser window taper unit: constants and shared types.
package kwt_pkg;
  localparam int unsigned MaxHalfLength = 1024;
  localparam int unsigned SeriesTerms   = 25;
  localparam logic [15:0] BetaLimit     = 16'd40960;
  localparam logic [23:0] StopRecip     = 24'd10000000;
  localparam int unsigned HalfW         = 11;
  localparam int unsigned BetaW         = 16;
  localparam logic [0:0]  RegHalf       = 1'b0;
  localparam logic [0:0]  RegBeta       = 1'b1;

  typedef struct packed {
    logic start;
    logic [63:0] y;
  } bes_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] sum;
  } bes_rsp_t;
endpackage

/* rtl/kwt_bessel.sv */
// Iterative I0 power series in Q32.32 on one 32x32 multiplier.
module kwt_bessel #(
  parameter int unsigned SERIES_TERMS = kwt_pkg::SeriesTerms
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kwt_pkg::bes_req_t req_i,
  output kwt_pkg::bes_rsp_t rsp_o
);
  import kwt_pkg::*;

  localparam int unsigned KW = $clog2(SERIES_TERMS + 1) + 1;

  // states
  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_MACC = 4'd2, S_DIV = 4'd3,
                         S_SQ = 4'd4, S_SQACC = 4'd5, S_STOP = 4'd6, S_DONE = 4'd7,
                         S_SMUL = 4'd8;

  logic [3:0]   st_q, st_d;
  logic [63:0]  y_q, term_q, sum_q, quo_q, rem_q;
  logic [63:0]  y_d, term_d, sum_d, quo_d, rem_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  ma_q, mb_q, ma_d, mb_d;
  logic [1:0]   pp_q, pp_d;
  logic [KW-1:0] k_q, k_d;
  logic [6:0]   dc_q, dc_d;
  logic [63:0]  pp;
  logic [31:0]  opa, opb;
  logic [64:0]  rtry;
  logic [63:0]  sq;

  assign opa = pp_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign opb = pp_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp  = opa * opb;
  assign rtry = {rem_q, quo_q[63]} - {{(65-KW){1'b0}}, k_q};

  always_comb begin
    st_d = st_q; y_d = y_q; term_d = term_q; sum_d = sum_q; sq = '0;
    acc_d = acc_q; quo_d = quo_q; rem_d = rem_q;
    ma_d = ma_q; mb_d = mb_q; pp_d = pp_q; k_d = k_q; dc_d = dc_q;
    rsp_o.done = 1'b0;
    rsp_o.sum  = sum_q;
    case (st_q)
      S_IDLE: if (req_i.start) begin
        y_d = req_i.y; term_d = 64'h1_0000_0000; sum_d = 64'h1_0000_0000;
        k_d = KW'(1); ma_d = 64'h1_0000_0000; mb_d = req_i.y;
        pp_d = 2'd0; acc_d = '0; st_d = S_MUL;
      end
      S_MUL, S_SQ, S_SMUL: begin
        // four partial products, one per cycle
        acc_d = acc_q + ({64'd0, pp} << {{1'b0, pp_q[1]} + {1'b0, pp_q[0]}, 5'd0});
        pp_d = pp_q + 2'd1;
        if (pp_q == 2'd3)
          st_d = (st_q == S_MUL) ? S_MACC : ((st_q == S_SQ) ? S_SQACC : S_STOP);
      end
      S_MACC: begin
        quo_d = (acc_q[127:96] != 0) ? '1 : acc_q[95:32];
        rem_d = '0; dc_d = 7'd64; st_d = S_DIV;
      end
      S_DIV: begin
        // restoring division by k, one bit per cycle
        if (!rtry[64]) begin
          rem_d = rtry[63:0]; quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[62:0], quo_q[63]}; quo_d = {quo_q[62:0], 1'b0};
        end
        dc_d = dc_q - 7'd1;
        if (dc_q == 7'd1) begin
          st_d = S_SQ; ma_d = quo_d; mb_d = quo_d; pp_d = 2'd0; acc_d = '0;
        end
      end
      S_SQACC: begin
        term_d = quo_q;
        sq = (acc_q[127:96] != 0) ? '1 : acc_q[95:32];
        sum_d = (sum_q > ~sq) ? '1 : sum_q + sq;
        // stop test product sq * 1e7 on the same multiplier
        ma_d = sq; mb_d = {40'd0, StopRecip}; pp_d = 2'd0; acc_d = '0;
        st_d = S_SMUL;
      end
      S_STOP: begin
        if ((acc_q[127:64] == '0 && acc_q[63:0] < sum_q) || k_q == KW'(SERIES_TERMS))
          st_d = S_DONE;
        else begin
          k_d = k_q + KW'(1); ma_d = term_q; mb_d = y_q;
          pp_d = 2'd0; acc_d = '0; st_d = S_MUL;
        end
      end
      S_DONE: begin rsp_o.done = 1'b1; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d; term_q <= term_d; sum_q <= sum_d; acc_q <= acc_d;
    quo_q <= quo_d; rem_q <= rem_d; ma_q <= ma_d; mb_q <= mb_d;
    pp_q <= pp_d; k_q <= k_d; dc_q <= dc_d;
  end
endmodule

/* rtl/kaiser_window_taper_unit.sv */
// Top level of the Kaiser window taper unit.
// Usage:
//  - Configuration by cfg_we_i/cfg_idx_i/cfg_wdata_i while idle; any valid
//    write drops the cached I0(beta).
//  - s_axis takes one item {offset, sample_re, sample_im}; m_axis returns
//    {windowed_re, windowed_im, taper_value, offset_error}.
//  - One item at a time: s_axis_tready is low from acceptance until the
//    result has been taken from the output register.
//  - Processing: a 40-bit fraction divide, a 21-step square root, one or two
//    I0 series runs (up to 25 terms each, bit-serial divide by k), a 16-step
//    quotient and two multiplies.
//  - An out-of-range offset skips the per-item math and returns zeros with error set.
//  - Reset clears control and the cache; half_length=1, beta=0.
//  - A stalled receiver holds the result; the next item waits for it.
module kaiser_window_taper_unit #(
  parameter int unsigned SERIES_TERMS    = kwt_pkg::SeriesTerms
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // offset[10:0], sample_re[26:11], sample_im[42:27]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // windowed_re, windowed_im, taper_value
  output logic        m_axis_tuser    // offset_error
);
  import kwt_pkg::*;

  localparam logic [3:0] T_IDLE = 4'd0, T_REF = 4'd1, T_REFW = 4'd2, T_FRAC = 4'd3,
                         T_SQRT = 4'd4, T_BES = 4'd5, T_BESW = 4'd6, T_QUO = 4'd7,
                         T_MUL = 4'd8, T_OUT = 4'd9;

  logic [3:0]  st_q, st_d;
  logic [10:0] half_q;
  logic [15:0] beta_q;
  logic        refv_q;
  logic [63:0] refb_q;
  logic [10:0] off_q;
  logic [15:0] sre_q, sim_q;
  logic [21:0] hh_q, rem_q;
  logic [41:0] frac_q;
  logic [5:0]  cnt_q;
  logic [40:0] sv_q;
  logic [20:0] sr_q;
  logic [63:0] num_q, qrem_q;
  logic [16:0] q16_q;
  logic [47:0] odata_q;
  logic        oerr_q, ovalid_q;
  logic [10:0] hcl;
  logic [15:0] bcl;
  bes_req_t    breq;
  bes_rsp_t    brsp;
  logic [64:0] qtry;
  logic [16:0] tap_r;
  logic [15:0] tap_c;

  always_comb begin
    hcl = (half_q == '0) ? 11'd1 : half_q;
    if (32'(hcl) > MaxHalfLength) hcl = 11'(MaxHalfLength);
    bcl = (beta_q > BetaLimit) ? BetaLimit : beta_q;
  end

  kwt_bessel #(.SERIES_TERMS(SERIES_TERMS)) u_bes (
    .clk_i, .rst_ni, .req_i(breq), .rsp_o(brsp)
  );

  function automatic logic [15:0] tprod(input logic [15:0] s, input logic [15:0] t);
    logic signed [33:0] p;
    p = $signed({{18{s[15]}}, s}) * $signed({18'd0, t}) + 34'sd16384;
    p = p >>> 15;
    if (p > 34'sd32767) tprod = 16'h7fff;
    else if (p < -34'sd32768) tprod = 16'h8000;
    else tprod = p[15:0];
  endfunction

  assign qtry = {qrem_q, 1'b0} - {1'b0, refb_q};
  assign tap_r = ({1'b0, q16_q[16:1]} + {16'd0, q16_q[0]});
  assign tap_c = (tap_r > 17'd32768) ? 16'd32768 : tap_r[15:0];

  always_comb begin
    st_d = st_q;
    breq.start = 1'b0;
    breq.y = '0;
    case (st_q)
      T_IDLE: if (s_axis_tvalid && s_axis_tready) st_d = refv_q ? T_FRAC : T_REF;
      T_REF: begin breq.start = 1'b1; breq.y = {28'd0, bcl, 20'd0}; st_d = T_REFW; end
      T_REFW: if (brsp.done) st_d = T_FRAC;
      T_FRAC: if (off_q > hcl) st_d = T_OUT; else if (cnt_q == 6'd40) st_d = T_SQRT;
      T_SQRT: if (cnt_q == 6'd21) st_d = T_BES;
      T_BES: begin
        breq.start = 1'b1; breq.y = {27'd0, 37'(bcl) * 37'(sr_q)}; st_d = T_BESW;
      end
      T_BESW: if (brsp.done) st_d = T_QUO;
      T_QUO: if (num_q >= refb_q || cnt_q == 6'd15) st_d = T_MUL;
      T_MUL: st_d = T_OUT;
      T_OUT: if (!ovalid_q) st_d = T_IDLE;
      default: st_d = T_IDLE;
    endcase
  end

  assign s_axis_tready = (st_q == T_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = oerr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= T_IDLE; half_q <= 11'd1; beta_q <= '0; refv_q <= 1'b0; refb_q <= '0;
      ovalid_q <= 1'b0; cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegHalf) half_q <= cfg_wdata_i[10:0];
        else beta_q <= cfg_wdata_i;
        refv_q <= 1'b0;
      end
      if (st_q == T_REFW && brsp.done) begin refb_q <= brsp.sum; refv_q <= 1'b1; end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (st_q == T_OUT && !ovalid_q) ovalid_q <= 1'b1;
      if (st_d != st_q) cnt_q <= '0;
      else if (st_q == T_FRAC || st_q == T_SQRT || st_q == T_QUO) cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      off_q <= s_axis_tdata[10:0]; sre_q <= s_axis_tdata[26:11];
      sim_q <= s_axis_tdata[42:27];
    end
    case (st_q)
      T_IDLE: begin
        hh_q <= 22'(hcl * hcl);
        rem_q <= 22'(hcl * hcl) - 22'(s_axis_tdata[10:0] * s_axis_tdata[10:0]);
        frac_q <= '0;
      end
      T_FRAC: begin
        if (cnt_q == 6'd0) begin
          frac_q <= {41'd0, rem_q >= hh_q};
          if (rem_q >= hh_q) rem_q <= '0;
        end else if (rem_q >= hh_q - rem_q) begin
          frac_q <= {frac_q[40:0], 1'b1}; rem_q <= rem_q - (hh_q - rem_q);
        end else begin
          frac_q <= {frac_q[40:0], 1'b0}; rem_q <= {rem_q[20:0], 1'b0};
        end
        if (cnt_q == 6'd40) begin sv_q <= '0; sr_q <= '0; end
        if (off_q > hcl) begin
          odata_q <= '0; oerr_q <= 1'b1;
        end
      end
      T_SQRT: begin
        // digit recurrence: two radicand bits per step
        if (cnt_q != 6'd21) begin : sq
          logic [42:0] rr, tt;
          rr = {sv_q[40:0], frac_q[41:40]};
          tt = {20'd0, sr_q, 2'b01};
          if (rr >= tt) begin sv_q <= 41'(rr - tt); sr_q <= {sr_q[19:0], 1'b1}; end
          else begin sv_q <= rr[40:0]; sr_q <= {sr_q[19:0], 1'b0}; end
          frac_q <= {frac_q[39:0], 2'b00};
        end
      end
      T_BESW: begin
        num_q <= brsp.sum; qrem_q <= brsp.sum; q16_q <= '0;
      end
      T_QUO: begin
        if (qtry[64] == 1'b0 && {qrem_q, 1'b0} >= {1'b0, refb_q}) begin
          qrem_q <= qtry[63:0]; q16_q <= {q16_q[15:0], 1'b1};
        end else begin
          qrem_q <= {qrem_q[62:0], 1'b0}; q16_q <= {q16_q[15:0], 1'b0};
        end
      end
      T_MUL: begin
        odata_q <= {((num_q >= refb_q) ? 16'd32768 : tap_c),
                    tprod(sim_q, (num_q >= refb_q) ? 16'd32768 : tap_c),
                    tprod(sre_q, (num_q >= refb_q) ? 16'd32768 : tap_c)};
        oerr_q <= 1'b0;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/kwt_checker.sv */
// Port-level checker for the Kaiser window taper unit, bound to the top level.
module kwt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("error item not zero");
  a_taper_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:32] <= 16'd32768)
    else $error("taper above one");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while result pending");
endmodule

bind kaiser_window_taper_unit kwt_checker u_kwt_checker (.*);

/* test/kwt_checker.sv */
// Scoreboard for the Kaiser window taper unit: predicts each result and compares.
module kwt_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // offset[10:0], sample_re[26:11], sample_im[42:27]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // windowed_re, windowed_im, taper_value
  input  logic        m_axis_tuser,   // offset_error
  output int          fail_count,
  output int          pending_count
);
  import kwt_pkg::*;

  typedef struct packed {
    logic [15:0] win_re;
    logic [15:0] win_im;
    logic [15:0] taper;
    logic        off_err;
  } taper_result_t;

  logic [10:0] half_reg;
  logic [15:0] beta_reg;
  logic [63:0] i0_beta;
  logic        i0_beta_ok;
  taper_result_t expected_q[$];

  function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) return '1;
    return p[95:32];
  endfunction

  // I0(2*y), y and the sum in Q32.32
  function automatic logic [63:0] bessel_series(logic [63:0] y);
    logic [63:0] sum, term, sq;
    logic [127:0] scaled;
    sum = 64'd1 << 32;
    term = sum;
    for (int k = 1; k <= SeriesTerms; k++) begin
      term = q32_mul(term, y) / 64'(k);
      sq = q32_mul(term, term);
      sum = (sum > ~sq) ? '1 : sum + sq;
      scaled = {64'd0, sq} * 128'd10000000;
      if (scaled < {64'd0, sum}) break;
    end
    return sum;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale_sample(logic [15:0] raw, logic [15:0] taper);
    logic signed [63:0] p;
    p = $signed({{48{raw[15]}}, raw}) * $signed({48'd0, taper}) + 64'sd16384;
    p = p >>> 15;
    if (p > 64'sd32767) p = 64'sd32767;
    if (p < -64'sd32768) p = -64'sd32768;
    return p[15:0];
  endfunction

  function automatic taper_result_t predict_taper(logic [47:0] item);
    taper_result_t res;
    logic [63:0] h, beta, d, frac, y, num, tap;
    logic [127:0] q;
    h = 64'(half_reg);
    if (h == 0) h = 1;
    if (h > 64'(MaxHalfLength)) h = 64'(MaxHalfLength);
    beta = 64'((beta_reg > BetaLimit) ? BetaLimit : beta_reg);
    d = 64'(item[10:0]);
    if (!i0_beta_ok) begin
      i0_beta = bessel_series(beta << 20);
      i0_beta_ok = 1'b1;
    end
    if (d > h) begin
      res = '0;
      res.off_err = 1'b1;
      return res;
    end
    q = {64'd0, h * h - d * d} << 40;
    frac = 64'(q / {64'd0, h * h});
    y = beta * floor_sqrt(frac);
    num = bessel_series(y);
    if (num >= i0_beta) tap = 64'd32768;
    else begin
      q = {64'd0, num} << 16;
      tap = 64'(((q / {64'd0, i0_beta}) + 128'd1) >> 1);
      if (tap > 64'd32768) tap = 64'd32768;
    end
    res.win_re = scale_sample(item[26:11], tap[15:0]);
    res.win_im = scale_sample(item[42:27], tap[15:0]);
    res.taper = tap[15:0];
    res.off_err = 1'b0;
    return res;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h, expected %h", field, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    taper_result_t want;
    if (!rst_ni) begin
      half_reg <= 11'd1;
      beta_reg <= 16'd0;
      i0_beta = '0;
      i0_beta_ok = 1'b0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegHalf) half_reg <= cfg_wdata_i[10:0];
        else beta_reg <= cfg_wdata_i;
        i0_beta_ok = 1'b0;
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(predict_taper(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result item %h/%b", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[15:0] !== want.win_re)
            report("windowed_re", m_axis_tdata[15:0], want.win_re);
          if (m_axis_tdata[31:16] !== want.win_im)
            report("windowed_im", m_axis_tdata[31:16], want.win_im);
          if (m_axis_tdata[47:32] !== want.taper)
            report("taper_value", m_axis_tdata[47:32], want.taper);
          if (m_axis_tuser !== want.off_err)
            report("offset_error", {15'd0, m_axis_tuser}, {15'd0, want.off_err});
        end
      end
    end
  end
endmodule

/* test/testbench.sv */
// Stimulus and verdict for the Kaiser window taper unit.
module testbench;
  import kwt_pkg::*;

  localparam int WatchdogLimit = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count, pending_count;
  logic        steady_mode = 1'b0;
  logic [10:0] cur_half = 11'd1;
  int          idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  kaiser_window_taper_unit dut (.*);

  kwt_scoreboard scoreboard (.*);

  function automatic int gap_len();
    if (steady_mode) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    int stall;
    stall = gap_len();
    if (stall > 0 && !steady_mode && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_window(logic [10:0] half, logic [15:0] beta);
    write_reg(RegHalf, {5'd0, half});
    write_reg(RegBeta, beta);
    cur_half = half;
  endtask

  task automatic send_item(logic [10:0] offset, logic [15:0] re, logic [15:0] im);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, im, re, offset};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic random_offset_items(int count);
    int h;
    logic [10:0] off;
    h = (cur_half == 0) ? 1 : (cur_half > MaxHalfLength ? MaxHalfLength : cur_half);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) off = 11'($urandom_range(0, 2047));
      else off = 11'($urandom_range(0, h));
      send_item(off, 16'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, then extremes of both registers
    send_item(11'd0, 16'h7fff, 16'h8000);
    send_item(11'd1, 16'h8000, 16'h7fff);
    send_item(11'd2, 16'h1234, 16'hffff);
    drain();
    set_window(11'd1024, 16'd40960);
    send_item(11'd0, 16'h7fff, 16'h8000);
    send_item(11'd512, 16'h8000, 16'h7fff);
    send_item(11'd1023, 16'h7fff, 16'h7fff);
    send_item(11'd1024, 16'h8000, 16'h8000);
    send_item(11'd1025, 16'h7fff, 16'h0001);
    send_item(11'd2047, 16'hffff, 16'hffff);
    drain();
    // zero half length acts as one, beta above the limit is clamped
    set_window(11'd0, 16'hffff);
    send_item(11'd0, 16'h4000, 16'hc000);
    send_item(11'd1, 16'h0001, 16'hffff);
    send_item(11'd2, 16'h7fff, 16'h8000);
    drain();
    // half length above the maximum is clamped
    set_window(11'd2047, 16'd2048);
    send_item(11'd1024, 16'h7fff, 16'h8000);
    send_item(11'd1025, 16'h7fff, 16'h8000);
    send_item(11'd700, 16'h5555, 16'haaaa);
    send_item(11'd0, 16'h0000, 16'h0000);
    drain();
    set_window(11'd7, 16'd0);
    send_item(11'd3, 16'h7fff, 16'h8000);
    send_item(11'd7, 16'h8000, 16'h7fff);
    send_item(11'd8, 16'h7fff, 16'h7fff);
    drain();

    // random phases; heavy beta gets few items since the series runs long
    for (int phase = 0; phase < 10; phase++) begin
      steady_mode = (phase % 4 == 3);
      case (phase)
        2: begin
          set_window(11'd1024, 16'd40960);
          random_offset_items(25);
        end
        5: begin
          set_window(11'd1, 16'($urandom_range(0, 65535)));
          random_offset_items(60);
        end
        default: begin
          set_window(11'($urandom_range(1, 1024)), 16'($urandom_range(0, 10000)));
          random_offset_items(90);
        end
      endcase
      drain();
    end

    steady_mode = 1'b0;
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
